// ===== hw/rtl/sapu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapu_pkg: shared definitions for the strip ADC packet unpacker
// Opcodes, field select codes, packet layout constants and the command
// bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package sapu_pkg;

	// opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ADC   = 2'd1;
	localparam logic [1:0] OP_FIELD = 2'd2;

	// field select codes
	localparam logic [4:0] FS_EVT     = 5'd0;
	localparam logic [4:0] FS_FLAG    = 5'd1;
	localparam logic [4:0] FS_DET     = 5'd2;
	localparam logic [4:0] FS_DIB     = 5'd3;
	localparam logic [4:0] FS_CIB     = 5'd4;
	localparam logic [4:0] FS_BCLK    = 5'd5;
	localparam logic [4:0] FS_RCCADDR = 5'd6;
	localparam logic [4:0] FS_NRCC    = 5'd7;
	localparam logic [4:0] FS_FW      = 5'd8;
	localparam logic [4:0] FS_CHMODE  = 5'd9;
	localparam logic [4:0] FS_PED     = 5'd10;
	localparam logic [4:0] FS_EN      = 5'd11;
	localparam logic [4:0] FS_HYBRID  = 5'd12;
	localparam logic [4:0] FS_RCCBCLK = 5'd13;
	localparam logic [4:0] FS_PAR     = 5'd14;
	localparam logic [4:0] FS_DCMPAR  = 5'd15;
	localparam logic [4:0] FS_L1      = 5'd16;

	// packet layout
	localparam int STORE_DEPTH_DEF = 8192;
	localparam int WORDS_PER_CHIP  = 387;
	localparam int CHIPS           = 12;
	localparam int CHANNELS        = 128;
	localparam int CH_TOTAL        = CHIPS * CHANNELS;
	localparam int HDR_WORDS       = 17;
	localparam int TRL_MODE        = 4662;
	localparam int TRL_FW          = 4663;
	localparam int TRL_PAR         = 4664;
	localparam int TRL_DCMPAR      = 4665;
	localparam int MIN_WORDS       = 4666;
	localparam int CARD_MAX        = 5;
	localparam int RCCADDR_BASE    = 5;
	localparam int HYBRID_BASE     = 8;
	localparam int BCLK_HI_BASE    = 11;
	localparam int BCLK_LO_BASE    = 14;
	localparam int ADC_OFFSET      = 3;

	// widths of fixed-layout quantities
	localparam int FA_W   = 13;
	localparam int CHIP_W = 4;
	localparam int CH_W   = 7;

	// controller to datapath commands
	typedef struct packed {
		logic wr;
		logic capture;
		logic calc;
		logic rd1;
		logic rd2;
		logic fmt;
	} cmd_t;

endpackage

// ===== hw/rtl/sapu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapu_ctrl: request sequencer
// Accepts load beats without leaving idle, walks read requests through decode,
// two store lookups, formatting and output hand-off.
// ----------------------------------------------------------------------------
module sapu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	output logic              out_valid,
	input  logic              out_stall,
	output sapu_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_RD1  = 3'd2;
	localparam logic [2:0] ST_RD2  = 3'd3;
	localparam logic [2:0] ST_FMT  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;
	logic       is_read;

	// input handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign accept    = in_valid && !in_stall;
	assign is_read   = (opcode == sapu_pkg::OP_ADC) || (opcode == sapu_pkg::OP_FIELD);

	// datapath commands
	always_comb begin
		cmd         = '0;
		cmd.wr      = accept && (opcode == sapu_pkg::OP_LOAD);
		cmd.capture = accept && is_read;
		cmd.calc    = (state_q == ST_CALC);
		cmd.rd1     = (state_q == ST_RD1);
		cmd.rd2     = (state_q == ST_RD2);
		cmd.fmt     = (state_q == ST_FMT);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_read) state_d = ST_CALC;
			end
			ST_CALC: state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = ST_FMT;
			ST_FMT:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a read beat yields its result after a fixed walk
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> ##5 out_valid)
		else $error("read result not presented on time");

	// no beat is taken while a result waits
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// a load beat leaves the block idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> (!out_valid && !in_stall))
		else $error("load beat disturbed the sequencer");

endmodule

// ===== hw/rtl/sapu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapu_dp: packet store and field decode datapath
// Holds the packet word store, the word count and a copy of the mode word,
// computes lookup addresses and formats the result of each read.
// ----------------------------------------------------------------------------
module sapu_dp #(
	parameter int STORE_DEPTH = sapu_pkg::STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sapu_pkg::cmd_t       cmd,
	input  logic [1:0]           opcode,
	input  logic                 first_word,
	input  logic [15:0]          word,
	input  logic [2:0]           rcc,
	input  logic [10:0]          channel_index,
	input  logic [4:0]           field_select,
	output logic [15:0]          value,
	output logic                 valid_res
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [15:0] mem [STORE_DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] wr_pos;
	logic          can_wr;
	logic [15:0]   mode_q;

	// captured request
	logic                      adc_q;
	logic [2:0]                rcc_q;
	logic [10:0]               chidx_q;
	logic [4:0]                sel_q;
	logic [sapu_pkg::CHIP_W-1:0] chip_q;
	logic [sapu_pkg::CHIP_W-1:0] chip_d;

	// decode results
	logic [AW-1:0] addr1_q;
	logic [AW-1:0] addr2_q;
	logic          ok_q;
	logic          zero_q;
	logic          card_on_q;
	logic          ok_d;
	logic          zero_d;
	logic          card_on;
	logic          card_ok;
	logic          in_range;
	logic          per_card;
	logic          complete;
	logic [7:0]    en8;
	logic [1:0]    pair;
	logic [sapu_pkg::FA_W-1:0] chip_base;
	logic [10:0]   ch_full;
	logic [sapu_pkg::FA_W-1:0] adc_addr;
	logic [sapu_pkg::FA_W-1:0] fld_addr;

	// lookup data
	logic [15:0] rd_data_q;
	logic [15:0] d1_q;
	logic [7:0]  byte_sel;
	logic [2:0]  nrcc;
	logic [15:0] fmt_val;
	logic [15:0] value_q;
	logic        valid_q;

	// load write position, restart on first word, saturate at depth
	assign wr_pos = first_word ? '0 : count_q;
	assign can_wr = (wr_pos < CW'(STORE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr) begin
			if (can_wr) count_q <= wr_pos + CW'(1);
			else count_q <= wr_pos;
		end
	end

	// store write and mode word copy
	always_ff @(posedge clk) begin
		if (cmd.wr && can_wr) begin
			mem[wr_pos[AW-1:0]] <= word;
			if (wr_pos == CW'(sapu_pkg::TRL_MODE)) mode_q <= word;
		end
	end

	// chip number by threshold compare
	always_comb begin
		chip_d = '0;
		for (int k = 1; k < sapu_pkg::CHIPS; k++) begin
			if (channel_index >= 11'(k * sapu_pkg::CHANNELS)) chip_d = sapu_pkg::CHIP_W'(k);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			adc_q   <= (opcode == sapu_pkg::OP_ADC);
			rcc_q   <= rcc;
			chidx_q <= channel_index;
			sel_q   <= field_select;
			chip_q  <= chip_d;
		end
	end

	// request checks
	assign en8      = {2'b00, mode_q[5:0]};
	assign card_ok  = (rcc_q <= 3'(sapu_pkg::CARD_MAX));
	assign card_on  = card_ok && en8[3'(sapu_pkg::CARD_MAX) - rcc_q];
	assign in_range = (chidx_q < 11'(sapu_pkg::CH_TOTAL));
	assign complete = (count_q >= CW'(sapu_pkg::MIN_WORDS));
	assign per_card = (sel_q == sapu_pkg::FS_RCCADDR) || (sel_q == sapu_pkg::FS_EN) ||
	                  (sel_q == sapu_pkg::FS_HYBRID) || (sel_q == sapu_pkg::FS_RCCBCLK) ||
	                  (sel_q == sapu_pkg::FS_L1);
	assign pair     = rcc_q[2:1];

	always_comb begin
		ok_d   = 1'b0;
		zero_d = 1'b0;
		priority if (!complete) begin
			ok_d = 1'b0;
		end else if (adc_q) begin
			ok_d   = card_ok && in_range;
			zero_d = !card_on;
		end else if (sel_q > sapu_pkg::FS_L1) begin
			ok_d = 1'b0;
		end else if (per_card && !card_ok) begin
			ok_d = 1'b0;
		end else if (per_card && (sel_q != sapu_pkg::FS_EN) && !card_on) begin
			zero_d = 1'b1;
			ok_d   = (sel_q != sapu_pkg::FS_L1) || in_range;
		end else if ((sel_q == sapu_pkg::FS_L1) && !in_range) begin
			ok_d = 1'b0;
		end else begin
			ok_d = 1'b1;
		end
	end

	// lookup addresses
	assign chip_base = sapu_pkg::FA_W'(chip_q) * sapu_pkg::FA_W'(sapu_pkg::WORDS_PER_CHIP)
	                 + sapu_pkg::FA_W'(sapu_pkg::HDR_WORDS);
	assign ch_full   = chidx_q - 11'(chip_q) * 11'(sapu_pkg::CHANNELS);
	assign adc_addr  = chip_base + sapu_pkg::FA_W'(sapu_pkg::ADC_OFFSET)
	                 + sapu_pkg::FA_W'(pair)
	                 + sapu_pkg::FA_W'(ch_full[sapu_pkg::CH_W-1:0] * 9'd3);

	always_comb begin
		unique case (sel_q)
			sapu_pkg::FS_EVT:     fld_addr = sapu_pkg::FA_W'(0);
			sapu_pkg::FS_FLAG:    fld_addr = sapu_pkg::FA_W'(1);
			sapu_pkg::FS_DET:     fld_addr = sapu_pkg::FA_W'(2);
			sapu_pkg::FS_DIB,
			sapu_pkg::FS_CIB:     fld_addr = sapu_pkg::FA_W'(3);
			sapu_pkg::FS_BCLK:    fld_addr = sapu_pkg::FA_W'(4);
			sapu_pkg::FS_RCCADDR: fld_addr = sapu_pkg::FA_W'(sapu_pkg::RCCADDR_BASE)
			                               + sapu_pkg::FA_W'(pair);
			sapu_pkg::FS_FW:      fld_addr = sapu_pkg::FA_W'(sapu_pkg::TRL_FW);
			sapu_pkg::FS_HYBRID:  fld_addr = sapu_pkg::FA_W'(sapu_pkg::HYBRID_BASE)
			                               + sapu_pkg::FA_W'(pair);
			sapu_pkg::FS_RCCBCLK: fld_addr = sapu_pkg::FA_W'(sapu_pkg::BCLK_HI_BASE)
			                               + sapu_pkg::FA_W'(pair);
			sapu_pkg::FS_PAR:     fld_addr = sapu_pkg::FA_W'(sapu_pkg::TRL_PAR);
			sapu_pkg::FS_DCMPAR:  fld_addr = sapu_pkg::FA_W'(sapu_pkg::TRL_DCMPAR);
			sapu_pkg::FS_L1:      fld_addr = chip_base + sapu_pkg::FA_W'(pair);
			default:              fld_addr = sapu_pkg::FA_W'(sapu_pkg::TRL_MODE);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr1_q   <= AW'(adc_q ? adc_addr : fld_addr);
			addr2_q   <= AW'(sapu_pkg::BCLK_LO_BASE) + AW'(pair);
			ok_q      <= ok_d;
			zero_q    <= zero_d;
			card_on_q <= card_on;
		end
	end

	// store lookups, one port, registered data
	always_ff @(posedge clk) begin
		if (cmd.rd1) rd_data_q <= mem[addr1_q];
		if (cmd.rd2) begin
			rd_data_q <= mem[addr2_q];
			d1_q      <= rd_data_q;
		end
	end

	// result formatting
	assign byte_sel = rcc_q[0] ? d1_q[15:8] : d1_q[7:0];

	always_comb begin
		nrcc = '0;
		for (int i = 0; i < 6; i++) begin
			nrcc = nrcc + 3'(mode_q[i]);
		end
	end

	always_comb begin
		if (adc_q) begin
			fmt_val = {8'h00, byte_sel};
		end else begin
			unique case (sel_q)
				sapu_pkg::FS_DIB:     fmt_val = {8'h00, d1_q[7:0]};
				sapu_pkg::FS_CIB:     fmt_val = {8'h00, d1_q[15:8]};
				sapu_pkg::FS_RCCADDR: fmt_val = {13'h0, byte_sel[2:0]};
				sapu_pkg::FS_NRCC:    fmt_val = {13'h0, nrcc};
				sapu_pkg::FS_CHMODE:  fmt_val = {15'h0, mode_q[15]};
				sapu_pkg::FS_PED:     fmt_val = {15'h0, mode_q[14]};
				sapu_pkg::FS_EN:      fmt_val = {15'h0, card_on_q};
				sapu_pkg::FS_HYBRID:  fmt_val = {12'h0, byte_sel[3:0]};
				sapu_pkg::FS_RCCBCLK: fmt_val = rcc_q[0] ? {d1_q[15:8], rd_data_q[15:8]}
				                                         : {d1_q[7:0], rd_data_q[7:0]};
				sapu_pkg::FS_L1:      fmt_val = {8'h00, byte_sel};
				default:              fmt_val = d1_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fmt) begin
			value_q <= (ok_q && !zero_q) ? fmt_val : 16'h0000;
			valid_q <= ok_q;
		end
	end

	assign value     = value_q;
	assign valid_res = valid_q;

	// word count never passes the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("word count beyond store depth");

	// a rejected read carries a zero value
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fmt |=> (valid_res || (value == 16'h0000)))
		else $error("nonzero value on invalid result");

endmodule

// ===== hw/rtl/strip_adc_packet_unpacker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_adc_packet_unpacker_unit: strip detector readout packet unpacker
// Stores a readout packet word by word and answers ADC byte and
// header/trailer field requests against the stored packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request beat: a load of
//   one packet word (first_word restarts the count), an ADC byte read, or a
//   header/trailer field read. Opcode 3 is taken and dropped.
//   Output channel (out_valid/out_stall) carries one result beat per read:
//   value and valid_res. Reads before 4666 words have arrived return zero
//   with valid_res low.
//   A load beat never stalls the input; a read beat occupies the block
//   through the decode step and two lookups through the single read port
//   of the packet store, plus any output stall. Its result is presented
//   after the decode, both lookups and the format step.
//   The input is stalled from the read beat until its result is taken; a
//   stalled result holds. Reset clears the word count and sequencer; store
//   contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module strip_adc_packet_unpacker_unit #(
	parameter int STORE_DEPTH = sapu_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        first_word,
	input  logic [15:0] word,
	input  logic [2:0]  rcc,
	input  logic [10:0] channel_index,
	input  logic [4:0]  field_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] value,
	output logic        valid_res
);

	sapu_pkg::cmd_t cmd;

	// sequencer
	sapu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// store and decode
	sapu_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.first_word    (first_word),
		.word          (word),
		.rcc           (rcc),
		.channel_index (channel_index),
		.field_select  (field_select),
		.value         (value),
		.valid_res     (valid_res)
	);

endmodule

// ===== verif/strip_adc_packet_unpacker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_adc_packet_unpacker_unit_tb: self-checking bench for the packet unpacker
// Loads full and short readout packets, issues ADC byte and
// header/trailer field reads around them, predicts every read result from a
// local image of the packet store and checks each result beat in order.
// Both channels idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module strip_adc_packet_unpacker_unit_tb;

	localparam logic [1:0] OP_NONE      = 2'd3;
	localparam logic [4:0] FS_BAD_TOP   = sapu_pkg::FS_L1 + 5'd15;
	localparam int         MAX_REPORTS  = 10;
	localparam int         STALL_LIMIT  = 5000;
	localparam int         HOLD_CYCLES  = 500;
	localparam int         HOLD_AFTER   = 40;
	localparam int         DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        first_word;
		logic [15:0] word;
		logic [2:0]  rcc;
		logic [10:0] channel_index;
		logic [4:0]  field_select;
	} unpack_req_t;

	typedef struct packed {
		logic [15:0] value;
		logic        valid_res;
	} readout_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode        = '0;
	logic        first_word    = 1'b0;
	logic [15:0] word          = '0;
	logic [2:0]  rcc           = '0;
	logic [10:0] channel_index = '0;
	logic [4:0]  field_select  = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [15:0] value;
	logic        valid_res;

	// bench state
	unpack_req_t request_q[$];
	readout_t    expected_readouts[$];
	logic [15:0] packet_image [0:sapu_pkg::STORE_DEPTH_DEF-1];
	int unsigned image_fill    = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors        = 0;
	int          results_taken = 0;
	int          hold_left     = 0;
	int          quiet_cycles  = 0;

	strip_adc_packet_unpacker_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.first_word   (first_word),
		.word         (word),
		.rcc          (rcc),
		.channel_index(channel_index),
		.field_select (field_select),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.valid_res    (valid_res)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// card enable mask sits in the low six bits of the mode word, card 0 at bit 5
	function automatic bit card_enabled(input int unsigned card);
		logic [5:0] mask;
		mask = packet_image[sapu_pkg::TRL_MODE][5:0];
		return mask[sapu_pkg::CARD_MAX - card];
	endfunction

	// even cards own the low byte of a shared word, odd cards the high byte
	function automatic logic [15:0] card_byte(input int unsigned addr, input int unsigned card);
		logic [15:0] w;
		w = packet_image[addr];
		return (card % 2) ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
	endfunction

	function automatic bit decode_field(input logic [4:0] sel, input int unsigned card,
			input int unsigned chidx, output logic [15:0] val);
		int unsigned pair;
		int unsigned n;
		bit          per_card;
		logic [15:0] mode;
		logic [15:0] hi;
		logic [15:0] lo;
		pair = card / 2;
		mode = packet_image[sapu_pkg::TRL_MODE];
		val = '0;
		per_card = (sel == sapu_pkg::FS_RCCADDR) || (sel == sapu_pkg::FS_EN) ||
			(sel == sapu_pkg::FS_HYBRID) || (sel == sapu_pkg::FS_RCCBCLK) ||
			(sel == sapu_pkg::FS_L1);
		if (sel > sapu_pkg::FS_L1)
			return 1'b0;
		if (per_card && card > sapu_pkg::CARD_MAX)
			return 1'b0;
		// disabled card reads zero, but an out-of-range l1 channel still fails
		if (per_card && sel != sapu_pkg::FS_EN && !card_enabled(card))
			return (sel != sapu_pkg::FS_L1) || (chidx < sapu_pkg::CH_TOTAL);
		case (sel)
			sapu_pkg::FS_EVT:     val = packet_image[0];
			sapu_pkg::FS_FLAG:    val = packet_image[1];
			sapu_pkg::FS_DET:     val = packet_image[2];
			sapu_pkg::FS_DIB:     val = {8'h00, packet_image[3][7:0]};
			sapu_pkg::FS_CIB:     val = {8'h00, packet_image[3][15:8]};
			sapu_pkg::FS_BCLK:    val = packet_image[4];
			sapu_pkg::FS_RCCADDR: val = card_byte(sapu_pkg::RCCADDR_BASE + pair, card) & 16'h0007;
			sapu_pkg::FS_NRCC: begin
				n = 0;
				for (int i = 0; i < 6; i++)
					n += mode[i];
				val = n[15:0];
			end
			sapu_pkg::FS_FW:      val = packet_image[sapu_pkg::TRL_FW];
			sapu_pkg::FS_CHMODE:  val = {15'd0, mode[15]};
			sapu_pkg::FS_PED:     val = {15'd0, mode[14]};
			sapu_pkg::FS_EN:      val = {15'd0, card_enabled(card)};
			sapu_pkg::FS_HYBRID:  val = card_byte(sapu_pkg::HYBRID_BASE + pair, card) & 16'h000f;
			sapu_pkg::FS_RCCBCLK: begin
				hi = packet_image[sapu_pkg::BCLK_HI_BASE + pair];
				lo = packet_image[sapu_pkg::BCLK_LO_BASE + pair];
				val = (card % 2) ? {hi[15:8], lo[15:8]} : {hi[7:0], lo[7:0]};
			end
			sapu_pkg::FS_PAR:     val = packet_image[sapu_pkg::TRL_PAR];
			sapu_pkg::FS_DCMPAR:  val = packet_image[sapu_pkg::TRL_DCMPAR];
			default: begin
				// l1 sample byte of the chip
				if (chidx >= sapu_pkg::CH_TOTAL)
					return 1'b0;
				val = card_byte(sapu_pkg::HDR_WORDS +
					(chidx / sapu_pkg::CHANNELS) * sapu_pkg::WORDS_PER_CHIP + pair, card);
			end
		endcase
		return 1'b1;
	endfunction

	// applies one accepted beat; returns 1 when a result beat is due
	function automatic bit unpack_beat(input unpack_req_t r, output readout_t res);
		int unsigned card;
		int unsigned chidx;
		int unsigned addr;
		logic [15:0] val;
		bit          ok;
		card = r.rcc;
		chidx = r.channel_index;
		val = '0;
		ok = 1'b0;
		res = '0;
		if (r.opcode == sapu_pkg::OP_LOAD) begin
			if (r.first_word)
				image_fill = 0;
			if (image_fill < sapu_pkg::STORE_DEPTH_DEF) begin
				packet_image[image_fill] = r.word;
				image_fill++;
			end
			return 1'b0;
		end
		if (r.opcode == OP_NONE)
			return 1'b0;
		if (image_fill >= sapu_pkg::MIN_WORDS) begin
			if (r.opcode == sapu_pkg::OP_ADC) begin
				if (card <= sapu_pkg::CARD_MAX && chidx < sapu_pkg::CH_TOTAL) begin
					ok = 1'b1;
					if (card_enabled(card)) begin
						addr = sapu_pkg::HDR_WORDS +
							(chidx / sapu_pkg::CHANNELS) * sapu_pkg::WORDS_PER_CHIP +
							sapu_pkg::ADC_OFFSET + card / 2 + (chidx % sapu_pkg::CHANNELS) * 3;
						val = card_byte(addr, card);
					end
				end
			end else begin
				ok = decode_field(r.field_select, card, chidx, val);
			end
		end
		res.value = ok ? val : 16'h0000;
		res.valid_res = ok;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	task automatic push_beat(input logic [1:0] op, input logic first, input logic [15:0] w,
			input logic [2:0] card, input logic [10:0] chidx, input logic [4:0] sel);
		unpack_req_t r;
		r = {op, first, w, card, chidx, sel};
		request_q.push_back(r);
	endtask

	// one packet with random content; the mode word carries the card mask
	task automatic load_packet(input logic [15:0] mode, input int unsigned nwords,
			input bit extreme_hdr);
		logic [15:0] w;
		int unsigned i;
		for (i = 0; i < nwords; i++) begin
			w = 16'($urandom);
			if (i == sapu_pkg::TRL_MODE)
				w = mode;
			else if (extreme_hdr && i == 0)
				w = 16'hffff;
			else if (extreme_hdr && i == 1)
				w = 16'h0000;
			push_beat(sapu_pkg::OP_LOAD, i == 0, w, 3'($urandom), 11'($urandom),
				5'($urandom));
		end
	endtask

	// mostly reads, a few appended words and dropped opcodes
	task automatic push_random_beats(input int count);
		int          pick;
		logic [2:0]  card;
		logic [10:0] chidx;
		logic [4:0]  sel;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			card = ($urandom_range(99) < 85) ? 3'($urandom_range(sapu_pkg::CARD_MAX))
			                                 : 3'($urandom_range(7));
			chidx = ($urandom_range(99) < 85) ? 11'($urandom_range(sapu_pkg::CH_TOTAL - 1))
			                                  : 11'($urandom_range(2047));
			sel = ($urandom_range(99) < 85) ? 5'($urandom_range(sapu_pkg::FS_L1))
			                                : 5'($urandom_range(31));
			if (pick < 3)
				push_beat(sapu_pkg::OP_LOAD, 1'b0, 16'($urandom), card, chidx, sel);
			else if (pick < 5)
				push_beat(OP_NONE, 1'($urandom), 16'($urandom), card, chidx, sel);
			else if (pick < 52)
				push_beat(sapu_pkg::OP_ADC, 1'($urandom), 16'($urandom), card, chidx, sel);
			else
				push_beat(sapu_pkg::OP_FIELD, 1'($urandom), 16'($urandom), card, chidx, sel);
		end
	endtask

	task automatic wait_drained;
		while (request_q.size() != 0 || in_valid || expected_readouts.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk) begin : drive_requests
		unpack_req_t beat;
		unpack_req_t nxt;
		readout_t    res;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				beat = {opcode, first_word, word, rcc, channel_index, field_select};
				if (unpack_beat(beat, res))
					expected_readouts.push_back(res);
			end
			// present the next beat once the current one is gone
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = request_q.pop_front();
					in_valid      <= 1'b1;
					opcode        <= nxt.opcode;
					first_word    <= nxt.first_word;
					word          <= nxt.word;
					rcc           <= nxt.rcc;
					channel_index <= nxt.channel_index;
					field_select  <= nxt.field_select;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin : check_readouts
		readout_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_taken++;
				if (expected_readouts.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result beat: value %h valid_res %b", value, valid_res);
				end else begin
					want = expected_readouts.pop_front();
					if (value !== want.value || valid_res !== want.valid_res) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("result %0d mismatch: value exp %h got %h, valid_res exp %b got %b",
								results_taken, want.value, value, want.valid_res, valid_res);
					end
				end
				if (results_taken == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			// long hold-off once, random stalls otherwise
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- test sequence
	initial begin : stimulus

		// sender idles a third of the time, receiver mostly stalls
		send_idle_pct = 33;
		recv_stall_pct = 79;

		// reads and a dropped opcode before any packet
		push_beat(sapu_pkg::OP_ADC, 1'b0, 16'h0000, 3'd0, 11'd0, sapu_pkg::FS_EVT);
		push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'hffff, 3'd5, 11'd0, sapu_pkg::FS_EVT);
		push_beat(OP_NONE, 1'b1, 16'hffff, 3'd7, 11'h7ff, 5'h1f);

		// one word short of a full packet, a read against it, then the last trailer word
		load_packet(16'h802d, sapu_pkg::MIN_WORDS - 1, 1'b1);
		push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'h0000, 3'd0, 11'd0, sapu_pkg::FS_DCMPAR);
		push_beat(sapu_pkg::OP_LOAD, 1'b0, 16'h5aa5, 3'd0, 11'd0, sapu_pkg::FS_EVT);

		// every field once, cards rotating across enabled and disabled ones
		for (int f = 0; f <= sapu_pkg::FS_L1; f++)
			push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'h0000, 3'(f % (sapu_pkg::CARD_MAX + 1)),
				11'(sapu_pkg::CH_TOTAL - 1), 5'(f));
		push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'h0000, 3'd0, 11'd0, FS_BAD_TOP);
		push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'h0000, 3'd0, 11'(sapu_pkg::CH_TOTAL),
			sapu_pkg::FS_L1);
		push_beat(sapu_pkg::OP_FIELD, 1'b0, 16'h0000, 3'd6, 11'd0, sapu_pkg::FS_EN);
		// adc corners: first and last channel, disabled card, bad card, bad channel
		push_beat(sapu_pkg::OP_ADC, 1'b0, 16'h0000, 3'd0, 11'd0, sapu_pkg::FS_EVT);
		push_beat(sapu_pkg::OP_ADC, 1'b1, 16'h0000, 3'd5, 11'(sapu_pkg::CH_TOTAL - 1),
			sapu_pkg::FS_EVT);
		push_beat(sapu_pkg::OP_ADC, 1'b0, 16'h0000, 3'd1, 11'd0, sapu_pkg::FS_EVT);
		push_beat(sapu_pkg::OP_ADC, 1'b0, 16'h0000, 3'd7, 11'd0, sapu_pkg::FS_EVT);
		push_beat(sapu_pkg::OP_ADC, 1'b0, 16'h0000, 3'd0, 11'h7ff, sapu_pkg::FS_EVT);

		push_random_beats(300);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// sender mostly idle, receiver stalls a third of the time
		send_idle_pct = 79;
		recv_stall_pct = 33;
		push_random_beats(300);
		wait_drained();

		// full rate, then a restarted packet cut short: reads must come back empty
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_random_beats(300);
		load_packet(16'($urandom), 100, 1'b0);
		push_random_beats(20);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_readouts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
